[rtl/core/per_frame_page_bump_allocator_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the per-frame page bump allocator
// Clocked on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef PER_FRAME_PAGE_BUMP_ALLOCATOR_MACROS_SVH
`define PER_FRAME_PAGE_BUMP_ALLOCATOR_MACROS_SVH

// same-cycle implication
`define PBA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PBA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/pba_pkg.sv]
// ----------------------------------------------------------------------------
// pba_pkg
// Types and constants shared by the page bump allocator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package pba_pkg;

  localparam int ACTION_W = 2;
  localparam int FRAME_W  = 3;
  localparam int BYTES_W  = 32;
  localparam int STATUS_W = 2;
  localparam int PAGE_W   = 3;

  // action codes
  localparam logic [ACTION_W-1:0] ACT_ALLOC   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_RETIRE  = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_RELEASE = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

  localparam logic [BYTES_W-1:0] MIN_PAGE_RESET = 32'd1048576;

  // configuration port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = APB_ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_MIN_PAGE = '0;

  // kinds of result the controller asks the datapath to stage
  localparam logic [2:0] RES_FIT     = 3'd0;
  localparam logic [2:0] RES_OPEN    = 3'd1;
  localparam logic [2:0] RES_DONE    = 3'd2;
  localparam logic [2:0] RES_INVALID = 3'd3;
  localparam logic [2:0] RES_FULL    = 3'd4;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [FRAME_W-1:0]  frame_index;
    logic [BYTES_W-1:0]  request_bytes;
    logic [BYTES_W-1:0]  align_bytes;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [PAGE_W-1:0]   page_index;
    logic [BYTES_W-1:0]  byte_offset;
    logic                page_opened;
    logic [BYTES_W-1:0]  page_bytes;
  } rsp_t;

  typedef struct packed {
    logic       load;
    logic       walk_start;
    logic       walk_step;
    logic       commit_fit;
    logic       commit_open;
    logic       retire;
    logic       release_all;
    logic       res_load;
    logic [2:0] res_kind;
    logic       out_load;
  } pba_cmd_t;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic                bad;
    logic                fit;
    logic                walk_done;
    logic                full;
    logic                out_free;
  } pba_stat_t;

endpackage

`default_nettype wire

[rtl/core/pba_stream_if.sv]
// ----------------------------------------------------------------------------
// pba_stream_if
// Valid/ready channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface pba_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/core/pba_ctrl.sv]
// ----------------------------------------------------------------------------
// pba_ctrl
// Sequencer for the allocator: request check, first-fit walk, page open,
// retire/release and hand-off of the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pba_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  output logic                    req_ready,
  input  wire pba_pkg::pba_stat_t stat,
  output pba_pkg::pba_cmd_t       cmd
);
  import pba_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_WALK   = 3'd2;
  localparam logic [2:0] S_OPEN   = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    req_ready  = 1'b0;
    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        priority if (stat.bad) begin
          cmd.res_load = 1'b1;
          cmd.res_kind = RES_INVALID;
          state_next   = S_FINISH;
        end else if (stat.action == ACT_RETIRE) begin
          cmd.retire   = 1'b1;
          cmd.res_load = 1'b1;
          cmd.res_kind = RES_DONE;
          state_next   = S_FINISH;
        end else if (stat.action == ACT_RELEASE) begin
          cmd.release_all = 1'b1;
          cmd.res_load    = 1'b1;
          cmd.res_kind    = RES_DONE;
          state_next      = S_FINISH;
        end else begin
          cmd.walk_start = 1'b1;
          state_next     = S_WALK;
        end
      end
      S_WALK: begin
        priority if (stat.fit) begin
          cmd.commit_fit = 1'b1;
          cmd.res_load   = 1'b1;
          cmd.res_kind   = RES_FIT;
          state_next     = S_FINISH;
        end else if (stat.walk_done) begin
          if (stat.full) begin
            cmd.res_load = 1'b1;
            cmd.res_kind = RES_FULL;
            state_next   = S_FINISH;
          end else begin
            state_next = S_OPEN;
          end
        end else begin
          cmd.walk_step = 1'b1;
        end
      end
      S_OPEN: begin
        cmd.commit_open = 1'b1;
        cmd.res_load    = 1'b1;
        cmd.res_kind    = RES_OPEN;
        state_next      = S_FINISH;
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/pba_datapath.sv]
// ----------------------------------------------------------------------------
// pba_datapath
// Page tables, per-frame page counts, request registers, the one-page-per-
// cycle fit pipeline and the result/output registers.
// ----------------------------------------------------------------------------
`default_nettype none

module pba_datapath #(
  parameter int FRAMES          = 3,
  parameter int PAGES_PER_FRAME = 8
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire pba_pkg::pba_cmd_t         cmd,
  output pba_pkg::pba_stat_t             stat,
  input  wire pba_pkg::req_t             req_data,
  input  wire logic [pba_pkg::BYTES_W-1:0] min_page_bytes,
  input  wire logic                      rsp_ready,
  output logic                           rsp_valid,
  output pba_pkg::rsp_t                  rsp_data
);
  import pba_pkg::*;

  localparam int SLOTS  = FRAMES * PAGES_PER_FRAME;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int FIDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int PIDX_W = (PAGES_PER_FRAME > 1) ? $clog2(PAGES_PER_FRAME) : 1;
  localparam int CNT_W  = $clog2(PAGES_PER_FRAME + 1);
  localparam logic [FRAME_W:0] FRAME_LIM = FRAMES[FRAME_W:0];
  localparam logic [CNT_W-1:0] PAGE_LIM  = PAGES_PER_FRAME[CNT_W-1:0];

  function automatic logic [SLOT_W-1:0] slot_of(input logic [FIDX_W-1:0] f,
                                                 input logic [PIDX_W-1:0] p);
    slot_of = SLOT_W'(int'(f) * PAGES_PER_FRAME + int'(p));
  endfunction

  // page tables: no reset, only opened entries are ever read
  logic [BYTES_W-1:0] size_mem [SLOTS];
  logic [BYTES_W-1:0] used_mem [SLOTS];
  logic [CNT_W-1:0]   page_count [FRAMES];

  // latched request
  logic [ACTION_W-1:0] action_q;
  logic [FRAME_W-1:0]  frame_q;
  logic [BYTES_W-1:0]  req_q;
  logic [BYTES_W-1:0]  align_q;
  logic [BYTES_W-1:0]  mask_q;
  logic [BYTES_W-1:0]  aligned_q;

  // walk pipeline
  logic [CNT_W-1:0]   walk_idx;
  logic               s1_valid;
  logic [CNT_W-1:0]   s1_idx;
  logic [BYTES_W:0]   s1_begin;
  logic [BYTES_W-1:0] s1_size;

  rsp_t res;
  rsp_t res_next;

  logic [FIDX_W-1:0]  fi;
  logic               frame_ok;
  logic [CNT_W-1:0]   cnt;
  logic [BYTES_W:0]   round_sum;
  logic               alloc_bad;
  logic [SLOT_W-1:0]  rd_slot;
  logic [SLOT_W-1:0]  fit_slot;
  logic [SLOT_W-1:0]  open_slot;
  logic [BYTES_W:0]   rd_begin;
  logic [BYTES_W+1:0] fit_sum;
  logic               fit;
  logic               s1_last;
  logic [BYTES_W-1:0] new_size;

  assign fi        = frame_q[FIDX_W-1:0];
  assign frame_ok  = {1'b0, frame_q} < FRAME_LIM;
  assign cnt       = frame_ok ? page_count[fi] : '0;
  assign round_sum = {1'b0, req_q} + {1'b0, mask_q};
  // carry out of request + (align - 1) means the aligned end overflows
  assign alloc_bad = !frame_ok || (req_q == '0) || (align_q == '0)
                     || ((align_q & mask_q) != '0) || round_sum[BYTES_W];

  assign rd_slot   = slot_of(fi, walk_idx[PIDX_W-1:0]);
  assign fit_slot  = slot_of(fi, s1_idx[PIDX_W-1:0]);
  assign open_slot = slot_of(fi, cnt[PIDX_W-1:0]);
  assign rd_begin  = ({1'b0, used_mem[rd_slot]} + {1'b0, mask_q}) & ~{1'b0, mask_q};
  assign fit_sum   = {1'b0, s1_begin} + {2'b00, req_q};
  assign fit       = s1_valid && (fit_sum <= {2'b00, s1_size});
  assign s1_last   = (s1_idx + CNT_W'(1)) == cnt;
  assign new_size  = (aligned_q > min_page_bytes) ? aligned_q : min_page_bytes;

  always_comb begin
    stat           = '0;
    stat.action    = action_q;
    stat.fit       = fit;
    stat.walk_done = (cnt == '0) || (s1_valid && s1_last);
    stat.full      = cnt >= PAGE_LIM;
    stat.out_free  = !rsp_valid || rsp_ready;
    unique case (action_q)
      ACT_ALLOC:   stat.bad = alloc_bad;
      ACT_RETIRE:  stat.bad = !frame_ok;
      ACT_RELEASE: stat.bad = 1'b0;
      default:     stat.bad = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action_q <= req_data.action;
      frame_q  <= req_data.frame_index;
      req_q    <= req_data.request_bytes;
      align_q  <= req_data.align_bytes;
      mask_q   <= req_data.align_bytes - BYTES_W'(1);
    end
    if (cmd.walk_start) begin
      aligned_q <= round_sum[BYTES_W-1:0] & ~mask_q;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_start) begin
      walk_idx <= '0;
      s1_valid <= 1'b0;
    end else if (cmd.walk_step) begin
      if (walk_idx < cnt) begin
        s1_valid <= 1'b1;
        s1_idx   <= walk_idx;
        s1_begin <= rd_begin;
        s1_size  <= size_mem[rd_slot];
        walk_idx <= walk_idx + CNT_W'(1);
      end else begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit_fit) begin
      used_mem[fit_slot] <= fit_sum[BYTES_W-1:0];
    end
    if (cmd.commit_open) begin
      used_mem[open_slot] <= req_q;
      size_mem[open_slot] <= new_size;
    end
    if (cmd.retire) begin
      for (int p = 0; p < PAGES_PER_FRAME; p++) begin
        used_mem[slot_of(fi, PIDX_W'(p))] <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int f = 0; f < FRAMES; f++) begin
        page_count[f] <= '0;
      end
    end else if (cmd.release_all) begin
      for (int f = 0; f < FRAMES; f++) begin
        page_count[f] <= '0;
      end
    end else if (cmd.commit_open) begin
      page_count[fi] <= cnt + CNT_W'(1);
    end
  end

  always_comb begin
    res_next = '0;
    unique case (cmd.res_kind)
      RES_FIT: begin
        res_next.status      = ST_OK;
        res_next.page_index  = PAGE_W'(s1_idx);
        res_next.byte_offset = s1_begin[BYTES_W-1:0];
        res_next.page_bytes  = s1_size;
      end
      RES_OPEN: begin
        res_next.status      = ST_OK;
        res_next.page_index  = PAGE_W'(cnt);
        res_next.page_opened = 1'b1;
        res_next.page_bytes  = new_size;
      end
      RES_DONE:    res_next.status = ST_OK;
      RES_INVALID: res_next.status = ST_INVALID;
      RES_FULL:    res_next.status = ST_FULL;
      default:     res_next.status = ST_INVALID;
    endcase
  end

  // staged result, held until the output register is free
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rsp_data <= res;
    end
  end

endmodule

`default_nettype wire

[rtl/core/per_frame_page_bump_allocator.sv]
// ----------------------------------------------------------------------------
// per_frame_page_bump_allocator
// Paged first-fit bump allocator for in-flight frames, with APB config port.
// ----------------------------------------------------------------------------
// One request is worked on at a time and gives one result. An allocate walks
// the frame's open pages through a two-stage fit pipeline that checks one page
// per cycle; a request that fits lands in the first page with room, one that
// finds no room opens a new page, and a frame with all eight pages open and no
// fit reports a full table. Retire, release and rejected requests skip the
// walk. The next request is taken while the previous result still waits in the
// output register. min_page_bytes sits at byte address 0 and must only be
// written while the block is idle.
// No clearing pass after reset.
`default_nettype none

module per_frame_page_bump_allocator #(
  parameter int FRAMES          = 3,
  parameter int PAGES_PER_FRAME = 8
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  pba_stream_if.sink                          req,
  pba_stream_if.source                        rsp,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [pba_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [pba_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [pba_pkg::APB_DATA_W-1:0] prdata,
  output logic                                pready
);
  import pba_pkg::*;

  logic [BYTES_W-1:0] min_page_bytes;
  logic               reg_hit;
  pba_cmd_t           cmd;
  pba_stat_t          stat;

  assign reg_hit = paddr[APB_ADDR_W-1:2] == REG_MIN_PAGE;
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? min_page_bytes : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_page_bytes <= MIN_PAGE_RESET;
    end else if (psel && penable && pwrite && reg_hit) begin
      min_page_bytes <= pwdata;
    end
  end

  pba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pba_datapath #(
    .FRAMES          (FRAMES),
    .PAGES_PER_FRAME (PAGES_PER_FRAME)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .req_data       (req.data),
    .min_page_bytes (min_page_bytes),
    .rsp_ready      (rsp.ready),
    .rsp_valid      (rsp.valid),
    .rsp_data       (rsp.data)
  );

endmodule

`default_nettype wire

[rtl/core/pba_checker.sv]
// ----------------------------------------------------------------------------
// pba_checker
// Port-level checks on the allocator result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "per_frame_page_bump_allocator_macros.svh"

module pba_checker (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          rsp_valid,
  input wire logic          rsp_ready,
  input wire pba_pkg::rsp_t rsp_data
);
  import pba_pkg::*;

  // a stalled result must not change
  `PBA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "result changed while stalled")

  // failed results carry no placement
  `PBA_ASSERT_NOW(a_err_clean, rsp_valid && rsp_data.status != ST_OK, rsp_data.page_index == '0 && rsp_data.byte_offset == '0 && !rsp_data.page_opened && rsp_data.page_bytes == '0, "failed result carries placement")

  // a freshly opened page starts at offset 0 and is never empty
  `PBA_ASSERT_NOW(a_open_base, rsp_valid && rsp_data.page_opened, rsp_data.status == ST_OK && rsp_data.byte_offset == '0 && rsp_data.page_bytes != '0, "opened page misplaced")

  // any placement lies inside its page
  `PBA_ASSERT_NOW(a_in_page, rsp_valid && rsp_data.page_bytes != '0, rsp_data.byte_offset < rsp_data.page_bytes, "offset outside page")

endmodule

bind per_frame_page_bump_allocator pba_checker u_pba_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_data  (rsp.data)
);

`default_nettype wire

[verif/tb_per_frame_page_bump_allocator.sv]
// ----------------------------------------------------------------------------
// tb_per_frame_page_bump_allocator
// Drives allocate, retire and release requests with random flow control on
// both channels and checks every result against a shadow page table kept in
// the testbench. min_page_bytes is reprogrammed over the APB port between
// phases, with read-back.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_per_frame_page_bump_allocator;
  import pba_pkg::*;

  localparam int FRAMES = 3;
  localparam int PAGES  = 8;
  localparam int SLOTS  = FRAMES * PAGES;

  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  pba_stream_if #(.T(req_t)) req_if ();
  pba_stream_if #(.T(rsp_t)) rsp_if ();

  per_frame_page_bump_allocator #(
    .FRAMES          (FRAMES),
    .PAGES_PER_FRAME (PAGES)
  ) u_top (
    .clk     (clk),
    .rst     (rst),
    .req     (req_if),
    .rsp     (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // shadow of the allocator state
  logic [BYTES_W-1:0] page_size_mem [SLOTS];
  logic [BYTES_W-1:0] page_used_mem [SLOTS];
  int unsigned        pages_open [FRAMES];
  logic [BYTES_W-1:0] min_page_shadow;

  rsp_t awaited_results[$];
  int   fail_count;
  int   send_idle_pct;
  int   recv_idle_pct;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic rsp_t predict_allocation(input req_t item);
    rsp_t res;
    logic [BYTES_W-1:0] mask;
    logic [BYTES_W-1:0] aligned;
    logic [BYTES_W-1:0] fresh;
    logic [63:0] start;
    int unsigned base;
    int unsigned cnt;
    int unsigned i;
    bit placed;
    res = '0;
    res.status = ST_OK;
    case (item.action)
      ACT_ALLOC: begin
        if (item.frame_index >= FRAMES || item.request_bytes == 0 ||
            item.align_bytes == 0 ||
            (item.align_bytes & (item.align_bytes - 32'd1)) != 0 ||
            item.request_bytes > 32'hFFFF_FFFF - (item.align_bytes - 32'd1)) begin
          res.status = ST_INVALID;
        end else begin
          mask = item.align_bytes - 32'd1;
          base = item.frame_index * PAGES;
          cnt = pages_open[item.frame_index];
          placed = 1'b0;
          // first fit over the pages already open
          for (i = 0; i < cnt && !placed; i++) begin
            start = (64'(page_used_mem[base+i]) + 64'(mask)) & ~64'(mask);
            if (start + 64'(item.request_bytes) <= 64'(page_size_mem[base+i])) begin
              page_used_mem[base+i] = BYTES_W'(start + 64'(item.request_bytes));
              res.page_index  = PAGE_W'(i);
              res.byte_offset = BYTES_W'(start);
              res.page_bytes  = page_size_mem[base+i];
              placed = 1'b1;
            end
          end
          if (!placed) begin
            if (cnt >= PAGES) begin
              res.status = ST_FULL;
            end else begin
              aligned = (item.request_bytes + mask) & ~mask;
              fresh = (aligned > min_page_shadow) ? aligned : min_page_shadow;
              page_size_mem[base+cnt] = fresh;
              page_used_mem[base+cnt] = item.request_bytes;
              pages_open[item.frame_index] = cnt + 1;
              res.page_index  = PAGE_W'(cnt);
              res.page_opened = 1'b1;
              res.page_bytes  = fresh;
            end
          end
        end
      end
      ACT_RETIRE: begin
        if (item.frame_index >= FRAMES) begin
          res.status = ST_INVALID;
        end else begin
          for (i = 0; i < PAGES; i++) page_used_mem[item.frame_index*PAGES+i] = '0;
        end
      end
      ACT_RELEASE: begin
        for (i = 0; i < SLOTS; i++) page_used_mem[i] = '0;
        for (i = 0; i < FRAMES; i++) pages_open[i] = 0;
      end
      default: begin
        res.status = ST_INVALID;
      end
    endcase
    return res;
  endfunction

  function automatic req_t make_req(input logic [ACTION_W-1:0] action,
                                    input logic [FRAME_W-1:0] frame,
                                    input logic [BYTES_W-1:0] bytes,
                                    input logic [BYTES_W-1:0] align);
    req_t r;
    r.action        = action;
    r.frame_index   = frame;
    r.request_bytes = bytes;
    r.align_bytes   = align;
    return r;
  endfunction

  function automatic req_t random_request();
    req_t r;
    int sel;
    int a;
    int b;
    sel = $urandom_range(0, 99);
    if (sel < 84)      r.action = ACT_ALLOC;
    else if (sel < 92) r.action = ACT_RETIRE;
    else if (sel < 96) r.action = ACT_RELEASE;
    else               r.action = ACT_UNUSED;
    if ($urandom_range(0, 99) < 88) r.frame_index = FRAME_W'($urandom_range(0, FRAMES-1));
    else                            r.frame_index = FRAME_W'($urandom_range(FRAMES, 7));
    sel = $urandom_range(0, 99);
    if (sel < 5)       r.request_bytes = '0;
    else if (sel < 10) r.request_bytes = $urandom;
    else if (sel < 13) r.request_bytes = 32'hFFFF_FFFF - $urandom_range(0, 255);
    else               r.request_bytes = $urandom_range(1, 32'd1 << $urandom_range(0, 20));
    sel = $urandom_range(0, 99);
    if (sel < 70)      r.align_bytes = 32'd1 << $urandom_range(0, 8);
    else if (sel < 82) r.align_bytes = 32'd1 << $urandom_range(9, 31);
    else if (sel < 87) r.align_bytes = '0;
    else if (sel < 93) r.align_bytes = $urandom;
    else begin
      // two bits set: never a power of two
      a = $urandom_range(0, 31);
      b = (a + 1 + $urandom_range(0, 30)) % 32;
      r.align_bytes = (32'd1 << a) | (32'd1 << b);
    end
    return r;
  endfunction

  task automatic issue_request(input req_t item);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= item;
    do @(posedge clk); while (!req_if.ready);
    awaited_results.insert(awaited_results.size(), predict_allocation(item));
  endtask

  task automatic stop_requests();
    req_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_results();
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic set_min_page(input logic [BYTES_W-1:0] value);
    drain_results();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_MIN_PAGE, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    min_page_shadow = value;
    // read back straight after the write
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== value) begin
      fail_count++;
      if (fail_count <= 10)
        $display("min_page_bytes read-back: expected %h, got %h", value, prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_rejected_requests();
    issue_request(make_req(ACT_ALLOC, 3'd3, 32'd64, 32'd8));
    issue_request(make_req(ACT_ALLOC, 3'd0, 32'd0, 32'd8));
    issue_request(make_req(ACT_ALLOC, 3'd1, 32'd64, 32'd0));
    issue_request(make_req(ACT_ALLOC, 3'd2, 32'd64, 32'd3));
    issue_request(make_req(ACT_ALLOC, 3'd0, 32'h8000_0001, 32'h8000_0000));
    issue_request(make_req(ACT_UNUSED, 3'd0, 32'd16, 32'd1));
    issue_request(make_req(ACT_RETIRE, 3'd7, 32'd0, 32'd0));
    stop_requests();
  endtask

  task automatic test_extreme_sizes();
    issue_request(make_req(ACT_ALLOC, 3'd0, 32'hFFFF_FFFF, 32'd1));
    // full page: the fit check must not wrap
    issue_request(make_req(ACT_ALLOC, 3'd0, 32'd1, 32'd1));
    issue_request(make_req(ACT_ALLOC, 3'd2, 32'd1, 32'h8000_0000));
    issue_request(make_req(ACT_ALLOC, 3'd2, 32'h7FFF_FFFF, 32'd1));
    issue_request(make_req(ACT_ALLOC, 3'd1, 32'd100, 32'd64));
    issue_request(make_req(ACT_ALLOC, 3'd1, 32'd8, 32'd64));
    stop_requests();
  endtask

  task automatic test_retire_and_release();
    issue_request(make_req(ACT_RETIRE, 3'd1, 32'd0, 32'd0));
    issue_request(make_req(ACT_ALLOC, 3'd1, 32'd8, 32'd16));
    issue_request(make_req(ACT_RELEASE, 3'd0, 32'd0, 32'd0));
    stop_requests();
  endtask

  task automatic test_page_table_full();
    // exact-size pages: each request opens one until the table is full
    repeat (PAGES + 1) issue_request(make_req(ACT_ALLOC, 3'd1, 32'd16, 32'd1));
    stop_requests();
  endtask

  task automatic test_random_traffic(input int count);
    repeat (count) issue_request(random_request());
    stop_requests();
  endtask

  always @(posedge clk) begin
    rsp_if.ready <= !rst && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    rsp_t exp_rsp;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (awaited_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("unexpected result transfer: %p", rsp_if.data);
      end else begin
        exp_rsp = awaited_results.pop_front();
        if (rsp_if.data.status !== exp_rsp.status ||
            rsp_if.data.page_index !== exp_rsp.page_index ||
            rsp_if.data.byte_offset !== exp_rsp.byte_offset ||
            rsp_if.data.page_opened !== exp_rsp.page_opened ||
            rsp_if.data.page_bytes !== exp_rsp.page_bytes) begin
          fail_count++;
          if (fail_count <= 10)
            $display("result mismatch: expected st %0d pg %0d off %h open %0d size %h, got st %0d pg %0d off %h open %0d size %h",
                     exp_rsp.status, exp_rsp.page_index, exp_rsp.byte_offset,
                     exp_rsp.page_opened, exp_rsp.page_bytes,
                     rsp_if.data.status, rsp_if.data.page_index,
                     rsp_if.data.byte_offset, rsp_if.data.page_opened,
                     rsp_if.data.page_bytes);
        end
      end
    end
  end

  initial begin
    fail_count = 0;
    send_idle_pct = 32;
    recv_idle_pct = 54;
    min_page_shadow = MIN_PAGE_RESET;
    for (int i = 0; i < FRAMES; i++) pages_open[i] = 0;
    rst          <= 1'b1;
    req_if.valid <= 1'b0;
    req_if.data  <= '0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_rejected_requests();
    test_extreme_sizes();
    test_retire_and_release();
    set_min_page(32'd1);
    test_page_table_full();

    set_min_page(32'hFFFF_FFFF);
    test_random_traffic(225);
    set_min_page(32'd64);
    test_random_traffic(225);

    send_idle_pct = 54;
    recv_idle_pct = 32;
    set_min_page(MIN_PAGE_RESET);
    test_random_traffic(225);
    set_min_page(32'd1);
    test_random_traffic(225);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_min_page(32'd4096);
    test_random_traffic(225);
    set_min_page($urandom_range(2, 65536));
    test_random_traffic(225);

    drain_results();
    fail_count += awaited_results.size();
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
